### rtl/core/jddm_pkg.sv
`timescale 1ns / 1ps

package jddm_pkg;

    localparam int FULL_SPEED = 90;

    localparam int JOY_W   = 8;
    localparam int MAG_W   = JOY_W;
    localparam int PULSE_W = 16;

    localparam int LIM_W       = $clog2(FULL_SPEED + 1);
    localparam int PROD_W      = PULSE_W + LIM_W;
    localparam int SPEED_SHIFT = $clog2(FULL_SPEED);
    localparam int RECIP_SHIFT = PROD_W + SPEED_SHIFT;
    localparam int RECIP_W     = PROD_W + 1;

    // Rounded-up reciprocal of FULL_SPEED; exact for every product below 2**PROD_W.
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(FULL_SPEED) - 64'd1) / 64'(FULL_SPEED));

    localparam int DIV5_MULT   = 410;
    localparam int DIV5_SHIFT  = 11;
    localparam int DIV3_MULT   = 342;
    localparam int DIV3_SHIFT  = 10;
    localparam int SMALL_MUL_W = 9;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = PULSE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_PULSE = 2'd0,
        REG_MAX_PULSE = 2'd1,
        REG_PERIOD    = 2'd2
    } cfg_reg_t;

    localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 16'd35000;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 16'd45000;
    localparam logic [PULSE_W-1:0] PERIOD_RST    = 16'd50000;

endpackage

### rtl/core/joystick_differential_drive_mixer_unit.sv
`timescale 1ns / 1ps

// Channel        Signals                                         Direction
// input          in_valid, in_ready, joy_x, joy_y                into the block
// result         out_valid, out_ready, pulse_left, pulse_right,  out of the block
//                dir_left, dir_right
// configuration  cfg_wr_en, cfg_index, cfg_data                  into the block
//
// A new sample is taken every cycle while in_ready is high; each sample passes an input register,
// a speed stage, a span multiply stage, a reciprocal multiply stage and the result register.
// Reset clears the stage valid bits and loads the default pulse settings.
// When out_ready is low, stages fill up behind the result register and in_ready falls
// only once all five stages hold a transaction.
module joystick_differential_drive_mixer_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [jddm_pkg::JOY_W-1:0] joy_x,
    input  logic signed [jddm_pkg::JOY_W-1:0] joy_y,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [jddm_pkg::PULSE_W-1:0]     pulse_left,
    output logic [jddm_pkg::PULSE_W-1:0]     pulse_right,
    output logic                             dir_left,
    output logic                             dir_right,
    input  logic                             cfg_wr_en,
    input  logic [jddm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jddm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import jddm_pkg::*;

    localparam int LANES = 2;

    function automatic logic [MAG_W-1:0] abs8(input logic [JOY_W-1:0] v);
        return v[JOY_W-1] ? MAG_W'(~v + 1'b1) : MAG_W'(v);
    endfunction

    function automatic logic [MAG_W-1:0] div5(input logic [MAG_W-1:0] v);
        logic [MAG_W+SMALL_MUL_W-1:0] t;
        t = v * SMALL_MUL_W'(DIV5_MULT);
        return MAG_W'(t >> DIV5_SHIFT);
    endfunction

    function automatic logic [MAG_W-1:0] div3(input logic [MAG_W-1:0] v);
        logic [MAG_W+SMALL_MUL_W-1:0] t;
        t = v * SMALL_MUL_W'(DIV3_MULT);
        return MAG_W'(t >> DIV3_SHIFT);
    endfunction

    function automatic logic [LIM_W-1:0] limit(input logic [MAG_W-1:0] s);
        return (s >= MAG_W'(FULL_SPEED)) ? LIM_W'(FULL_SPEED) : LIM_W'(s);
    endfunction

    logic [PULSE_W-1:0] min_pulse_reg;
    logic [PULSE_W-1:0] max_pulse_reg;
    logic [PULSE_W-1:0] period_reg;

    logic v0_reg, v1_reg, v2_reg, v3_reg, vo_reg;
    logic en1, en2, en3, eno;

    logic [JOY_W-1:0]   x_reg, y_reg;
    logic [LIM_W-1:0]   lim1_reg [LANES];
    logic               nz1_reg  [LANES];
    logic [PROD_W-1:0]  prod2_reg [LANES];
    logic               nz2_reg  [LANES];
    logic [PULSE_W-1:0] quot3_reg [LANES];
    logic               nz3_reg  [LANES];
    logic [LANES-1:0]   dir1_reg, dir2_reg, dir3_reg, diro_reg;
    logic [PULSE_W-1:0] pulse_reg [LANES];

    logic [MAG_W-1:0]   ax, ay, hi, lo, inner, spin;
    logic [MAG_W-1:0]   speed [LANES];
    logic [LANES-1:0]   dir_next;
    logic [PULSE_W-1:0] span;
    logic [PROD_W+RECIP_W-1:0] full [LANES];
    logic [PULSE_W:0]   sum [LANES];
    logic [PULSE_W-1:0] pulse_next [LANES];

    assign eno      = !vo_reg || out_ready;
    assign en3      = !v3_reg || eno;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = !v0_reg || en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pulse_reg <= MIN_PULSE_RST;
            max_pulse_reg <= MAX_PULSE_RST;
            period_reg    <= PERIOD_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MIN_PULSE: min_pulse_reg <= cfg_data;
                REG_MAX_PULSE: max_pulse_reg <= cfg_data;
                REG_PERIOD:    period_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                v0_reg <= in_valid;
            end
            if (en1)
            begin
                v1_reg <= v0_reg;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (eno)
            begin
                vo_reg <= v3_reg;
            end
        end
    end

    // Speed stage: magnitudes, mixing and direction bits.
    always_comb
    begin
        ax    = abs8(x_reg);
        ay    = abs8(y_reg);
        hi    = (ay > ax) ? ay : ax;
        lo    = (ay > ax) ? ax : ay;
        inner = (hi == lo) ? div3(hi) : lo;
        spin  = div5(ax);
        dir_next = {LANES{(ay != '0) && !y_reg[JOY_W-1]}};
        if (ax == '0 && ay == '0)
        begin
            speed[0] = '0;
            speed[1] = '0;
        end
        else if (ay == '0)
        begin
            speed[0] = spin;
            speed[1] = spin;
            dir_next = {!x_reg[JOY_W-1], x_reg[JOY_W-1]};
        end
        else if (ax == '0)
        begin
            speed[0] = ay;
            speed[1] = ay;
        end
        else if (!x_reg[JOY_W-1])
        begin
            speed[0] = inner;
            speed[1] = hi;
        end
        else
        begin
            speed[0] = hi;
            speed[1] = inner;
        end
    end

    assign span = (max_pulse_reg >= min_pulse_reg) ? (max_pulse_reg - min_pulse_reg) : '0;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            full[i] = prod2_reg[i] * RECIP;
            sum[i]  = {1'b0, min_pulse_reg} + {1'b0, quot3_reg[i]};
            if (!nz3_reg[i])
            begin
                pulse_next[i] = '0;
            end
            else if (sum[i] > {1'b0, period_reg})
            begin
                pulse_next[i] = period_reg;
            end
            else
            begin
                pulse_next[i] = sum[i][PULSE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_reg <= joy_x;
            y_reg <= joy_y;
        end
        if (en1)
        begin
            dir1_reg <= dir_next;
        end
        if (en2)
        begin
            dir2_reg <= dir1_reg;
        end
        if (en3)
        begin
            dir3_reg <= dir2_reg;
        end
        if (eno)
        begin
            diro_reg <= dir3_reg;
        end
        for (int i = 0; i < LANES; i++)
        begin
            if (en1)
            begin
                lim1_reg[i] <= limit(speed[i]);
                nz1_reg[i]  <= (speed[i] != '0);
            end
            if (en2)
            begin
                prod2_reg[i] <= span * lim1_reg[i];
                nz2_reg[i]   <= nz1_reg[i];
            end
            if (en3)
            begin
                quot3_reg[i] <= PULSE_W'(full[i] >> RECIP_SHIFT);
                nz3_reg[i]   <= nz2_reg[i];
            end
            if (eno)
            begin
                pulse_reg[i] <= pulse_next[i];
            end
        end
    end

    assign out_valid   = vo_reg;
    assign pulse_left  = pulse_reg[0];
    assign pulse_right = pulse_reg[1];
    assign dir_left    = diro_reg[0];
    assign dir_right   = diro_reg[1];

endmodule

### rtl/core/jddm_checker.sv
`timescale 1ns / 1ps

module jddm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [jddm_pkg::PULSE_W-1:0]     pulse_left,
    input logic [jddm_pkg::PULSE_W-1:0]     pulse_right,
    input logic                             dir_left,
    input logic                             dir_right
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pulse_left)
            && $stable(pulse_right) && $stable(dir_left) && $stable(dir_right))
        else $error("result transaction changed while stalled");

    // Input back-pressure only appears behind a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a stalled result");

    // Opposite directions only occur when spinning in place, with equal pulses.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (dir_left != dir_right) |-> pulse_left == pulse_right)
        else $error("spin result with unequal pulses");

    // No result is offered straight out of reset.
    assert property (@(posedge clk)
        !$past(rst_n) |-> !out_valid)
        else $error("result offered directly after reset");

endmodule

bind joystick_differential_drive_mixer_unit jddm_checker u_jddm_checker (.*);

### tb/joystick_differential_drive_mixer_unit_test.sv
`timescale 1ns / 1ps

module joystick_differential_drive_mixer_unit_test;

    import jddm_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASE_ITEMS = 75;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [PULSE_W-1:0] pulse_left;
        logic [PULSE_W-1:0] pulse_right;
        logic               dir_left;
        logic               dir_right;
    } mix_result_t;

    class mixer_scoreboard;
        logic [PULSE_W-1:0] min_pulse;
        logic [PULSE_W-1:0] max_pulse;
        logic [PULSE_W-1:0] period;
        mix_result_t        pending_mixes[$];
        int                 errors;

        function new();
            min_pulse = MIN_PULSE_RST;
            max_pulse = MAX_PULSE_RST;
            period    = PERIOD_RST;
            errors    = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_MIN_PULSE: min_pulse = value;
                REG_MAX_PULSE: max_pulse = value;
                REG_PERIOD:    period = value;
                default: ;
            endcase
        endfunction

        function logic [PULSE_W-1:0] pulse_for_speed(int unsigned speed);
            int unsigned span;
            int unsigned lim;
            int unsigned width;
            if (speed == 0)
                return '0;
            span  = (max_pulse >= min_pulse) ? max_pulse - min_pulse : 0;
            lim   = (speed < FULL_SPEED) ? speed : FULL_SPEED;
            width = min_pulse + (span * lim) / FULL_SPEED;
            if (width > period)
                width = period;
            return width[PULSE_W-1:0];
        endfunction

        function void note_sample(logic signed [JOY_W-1:0] x, logic signed [JOY_W-1:0] y);
            int          sx;
            int          sy;
            int unsigned ax;
            int unsigned ay;
            int unsigned hi;
            int unsigned lo;
            int unsigned inner;
            mix_result_t mix;
            sx = x;
            sy = y;
            ax = (sx < 0) ? -sx : sx;
            ay = (sy < 0) ? -sy : sy;
            mix.dir_left  = (sy > 0);
            mix.dir_right = (sy > 0);
            if (ax == 0 && ay == 0)
            begin
                mix.pulse_left  = '0;
                mix.pulse_right = '0;
            end
            else if (ay == 0)
            begin
                mix.pulse_left  = pulse_for_speed(ax / 5);
                mix.pulse_right = mix.pulse_left;
                mix.dir_left    = (sx < 0);
                mix.dir_right   = (sx > 0);
            end
            else if (ax == 0)
            begin
                mix.pulse_left  = pulse_for_speed(ay);
                mix.pulse_right = mix.pulse_left;
            end
            else
            begin
                hi    = (ay > ax) ? ay : ax;
                lo    = (ay > ax) ? ax : ay;
                inner = (hi == lo) ? hi / 3 : lo;
                if (sx > 0)
                begin
                    mix.pulse_left  = pulse_for_speed(inner);
                    mix.pulse_right = pulse_for_speed(hi);
                end
                else
                begin
                    mix.pulse_left  = pulse_for_speed(hi);
                    mix.pulse_right = pulse_for_speed(inner);
                end
            end
            pending_mixes.push_back(mix);
        endfunction

        function void check_result(mix_result_t got);
            mix_result_t want;
            if (pending_mixes.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result %0d/%0d dir %b%b", $time,
                             got.pulse_left, got.pulse_right, got.dir_left, got.dir_right);
                return;
            end
            want = pending_mixes.pop_front();
            if (got.pulse_left !== want.pulse_left || got.pulse_right !== want.pulse_right ||
                got.dir_left !== want.dir_left || got.dir_right !== want.dir_right)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch, expected %0d/%0d dir %b%b, got %0d/%0d dir %b%b",
                             $time, want.pulse_left, want.pulse_right, want.dir_left,
                             want.dir_right, got.pulse_left, got.pulse_right, got.dir_left,
                             got.dir_right);
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [JOY_W-1:0]       joy_x;
    logic signed [JOY_W-1:0]       joy_y;
    logic                          out_valid;
    logic                          out_ready;
    logic [PULSE_W-1:0]            pulse_left;
    logic [PULSE_W-1:0]            pulse_right;
    logic                          dir_left;
    logic                          dir_right;
    logic                          cfg_wr_en;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;

    mixer_scoreboard mixes;
    bit              idling_on;
    int              stall_left;
    int              cycle_count;

    joystick_differential_drive_mixer_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .joy_x       (joy_x),
        .joy_y       (joy_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pulse_left  (pulse_left),
        .pulse_right (pulse_right),
        .dir_left    (dir_left),
        .dir_right   (dir_right),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (idling_on && stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (idling_on && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 15);
            end
        end
    end

    always @(posedge clk)
    begin
        mix_result_t got;
        if (out_valid === 1'b1 && out_ready === 1'b1)
        begin
            got.pulse_left  = pulse_left;
            got.pulse_right = pulse_right;
            got.dir_left    = dir_left;
            got.dir_right   = dir_right;
            mixes.check_result(got);
        end
    end

    task automatic send_sample(input int x, input int y);
        @(negedge clk);
        in_valid <= 1'b1;
        joy_x    <= x[JOY_W-1:0];
        joy_y    <= y[JOY_W-1:0];
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        mixes.note_sample(joy_x, joy_y);
    endtask

    task automatic idle_sender(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (mixes.pending_mixes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        mixes.set_register(idx, value);
    endtask

    task automatic set_pulses(input int min_ns, input int max_ns, input int cycle_ns);
        write_register(REG_MIN_PULSE, min_ns[CFG_DATA_W-1:0]);
        write_register(REG_MAX_PULSE, max_ns[CFG_DATA_W-1:0]);
        write_register(REG_PERIOD, cycle_ns[CFG_DATA_W-1:0]);
    endtask

    task automatic random_samples(input int count);
        int x;
        int y;
        int m;
        int pick;
        repeat (count)
        begin
            if (idling_on && $urandom_range(0, 5) == 0)
                idle_sender($urandom_range(1, 15));
            pick = $urandom_range(0, 9);
            x = $urandom_range(0, 255) - 128;
            y = $urandom_range(0, 255) - 128;
            case (pick)
                5: y = 0;
                6: x = 0;
                7:
                begin
                    m = $urandom_range(1, 128);
                    x = $urandom_range(0, 1) ? -m : m;
                    y = $urandom_range(0, 1) ? -m : m;
                end
                8:
                begin
                    x = $urandom_range(0, 12) - 6;
                    y = $urandom_range(0, 12) - 6;
                end
                9:
                begin
                    x = $urandom_range(0, 1) ? 127 : -128;
                    y = $urandom_range(0, 2) - 1;
                    if ($urandom_range(0, 1))
                    begin
                        m = x;
                        x = y;
                        y = m;
                    end
                end
                default: ;
            endcase
            send_sample(x, y);
        end
    endtask

    initial
    begin
        mixes       = new();
        cycle_count = 0;
        idling_on   = 1'b1;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        joy_x       = '0;
        joy_y       = '0;
        out_ready   = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Centre, spin in place, straight runs, diagonals and the most negative inputs.
        send_sample(0, 0);
        send_sample(127, 0);
        send_sample(-128, 0);
        send_sample(4, 0);
        send_sample(-4, 0);
        send_sample(5, 0);
        send_sample(0, 127);
        send_sample(0, -128);
        send_sample(0, 1);
        send_sample(0, -1);
        send_sample(0, 90);
        send_sample(0, 89);
        send_sample(127, 127);
        send_sample(-128, -128);
        send_sample(50, 50);
        send_sample(-50, 50);
        send_sample(1, 1);
        send_sample(2, -2);
        send_sample(100, 20);
        send_sample(-20, 100);
        send_sample(20, -100);
        send_sample(-100, -20);
        send_sample(127, -128);
        send_sample(-128, 127);
        random_samples(PHASE_ITEMS);
        wait_for_drain();

        set_pulses(0, 65535, 65535);
        write_register(REG_UNUSED, 16'h1234);
        random_samples(PHASE_ITEMS);
        wait_for_drain();

        // Inverted span: every nonzero speed gives the minimum width.
        set_pulses(65535, 0, 65535);
        send_sample(-128, 0);
        send_sample(0, 1);
        random_samples(PHASE_ITEMS);
        wait_for_drain();

        set_pulses(1000, 60000, 30000);
        random_samples(PHASE_ITEMS);
        wait_for_drain();

        set_pulses(35000, 45000, 0);
        random_samples(PHASE_ITEMS);
        wait_for_drain();

        set_pulses($urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535));
        random_samples(PHASE_ITEMS);
        wait_for_drain();

        idling_on = 1'b0;
        set_pulses($urandom_range(0, 30000), $urandom_range(30000, 65535),
                   $urandom_range(20000, 65535));
        random_samples(PHASE_ITEMS);
        wait_for_drain();

        if (mixes.errors == 0 && mixes.pending_mixes.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
